FILE: design/assert_macros.svh
// Assertion shorthands for the RTL files; included by the controller.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_IMPLIES(name, ck, rn, cond, expr) \
  name: assert property (@(posedge ck) disable iff (!rn) (cond) |-> (expr)) \
    else $error("assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NEXT(name, ck, rn, cond, expr) \
  name: assert property (@(posedge ck) disable iff (!rn) (cond) |=> (expr)) \
    else $error("assertion failed");

`endif

FILE: design/mes_pkg.sv
package mes_pkg;

  localparam int AXIS_BITS_DEF  = 10;
  localparam int COORD_BITS_DEF = 12;

  // Decision variable width; arithmetic wraps modulo 2**DEC_W.
  localparam int DEC_W = 64;

  localparam int IN_TDATA_W = 8;
  localparam int CFG_IDX_W  = 2;

  localparam logic [CFG_IDX_W-1:0] CFG_CENTER_X = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CENTER_Y = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_AXIS_X   = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_AXIS_Y   = 2'd3;

  // Multiplier operations: operand selection and destination register.
  localparam int MUL_W = 4;
  localparam logic [MUL_W-1:0] MUL_NONE = 4'd0;
  localparam logic [MUL_W-1:0] MUL_AA   = 4'd1;
  localparam logic [MUL_W-1:0] MUL_BB   = 4'd2;
  localparam logic [MUL_W-1:0] MUL_B2X  = 4'd3;
  localparam logic [MUL_W-1:0] MUL_A2Y  = 4'd4;
  localparam logic [MUL_W-1:0] MUL_A2B  = 4'd5;
  localparam logic [MUL_W-1:0] MUL_XX1  = 4'd6;
  localparam logic [MUL_W-1:0] MUL_YSQ  = 4'd7;
  localparam logic [MUL_W-1:0] MUL_B2T1 = 4'd8;
  localparam logic [MUL_W-1:0] MUL_A2T2 = 4'd9;
  localparam logic [MUL_W-1:0] MUL_A2B2 = 4'd10;

  // Accumulator operations on the decision register.
  localparam int ACC_OP_W = 2;
  localparam logic [ACC_OP_W-1:0] ACC_HOLD = 2'd0;
  localparam logic [ACC_OP_W-1:0] ACC_LOAD = 2'd1;
  localparam logic [ACC_OP_W-1:0] ACC_ADD  = 2'd2;
  localparam logic [ACC_OP_W-1:0] ACC_SUB  = 2'd3;

  // Accumulator source terms.
  localparam int SRC_W = 4;
  localparam logic [SRC_W-1:0] SRC_A2   = 4'd0;
  localparam logic [SRC_W-1:0] SRC_4B2  = 4'd1;
  localparam logic [SRC_W-1:0] SRC_4M   = 4'd2;
  localparam logic [SRC_W-1:0] SRC_B2   = 4'd3;
  localparam logic [SRC_W-1:0] SRC_8BX  = 4'd4;
  localparam logic [SRC_W-1:0] SRC_8AY  = 4'd5;
  localparam logic [SRC_W-1:0] SRC_8A2  = 4'd6;
  localparam logic [SRC_W-1:0] SRC_8B2  = 4'd7;
  localparam logic [SRC_W-1:0] SRC_12A2 = 4'd8;
  localparam logic [SRC_W-1:0] SRC_12B2 = 4'd9;

  typedef struct packed {
    logic [MUL_W-1:0]    mul_op;
    logic [ACC_OP_W-1:0] acc_op;
    logic [SRC_W-1:0]    acc_src;
    logic                off_load;
    logic                x_inc;
    logic                y_dec;
    logic                emit;
    logic                emit_last;
    logic                emit_fin;
  } mes_cmd_t;

  typedef struct packed {
    logic below;     // b^2*x < a^2*y
    logic dec_neg;
    logic dec_zero;
    logic y_zero;
  } mes_sts_t;

endpackage

FILE: design/mes_datapath.sv
module mes_datapath import mes_pkg::*; #(
  parameter int AXIS_BITS  = AXIS_BITS_DEF,
  parameter int COORD_BITS = COORD_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  mes_cmd_t                     cmd,
  output mes_sts_t                     sts,
  input  logic signed [COORD_BITS-1:0] center_x,
  input  logic signed [COORD_BITS-1:0] center_y,
  input  logic [AXIS_BITS-1:0]         semi_axis_x,
  input  logic [AXIS_BITS-1:0]         semi_axis_y,
  output logic [COORD_BITS:0]          x_plus,
  output logic [COORD_BITS:0]          x_minus,
  output logic [COORD_BITS:0]          y_plus,
  output logic [COORD_BITS:0]          y_minus,
  output logic                         last_step,
  output logic                         finished
);

  localparam int OFF_BITS = AXIS_BITS + 1;
  localparam int OUT_BITS = COORD_BITS + 1;
  localparam int MA       = 2 * AXIS_BITS;
  localparam int MB       = 2 * OFF_BITS;
  localparam int PW       = MA + MB;
  localparam int SW       = ((OUT_BITS > OFF_BITS) ? OUT_BITS : OFF_BITS) + 1;

  logic [OFF_BITS-1:0] x_r, y_r;
  logic [DEC_W-1:0]    d_r;
  logic [MA-1:0]       a2_r, b2_r;
  logic [MB-1:0]       t1_r, t2_r;
  logic [PW-1:0]       bx_r, ay_r, m_r;

  logic [MA-1:0]       ma;
  logic [MB-1:0]       mb;
  logic [PW-1:0]       prod;
  logic [OFF_BITS-1:0] ym1_abs;
  logic [MA+1:0]       a2x3, b2x3;
  logic [DEC_W-1:0]    term;

  // |y - 1|, as used by the region-2 start value.
  assign ym1_abs = (y_r == '0) ? OFF_BITS'(1) : (y_r - OFF_BITS'(1));

  always_comb begin
    ma = '0;
    mb = '0;
    unique case (cmd.mul_op)
      MUL_AA: begin
        ma = MA'(semi_axis_x);
        mb = MB'(semi_axis_x);
      end
      MUL_BB: begin
        ma = MA'(semi_axis_y);
        mb = MB'(semi_axis_y);
      end
      MUL_B2X: begin
        ma = b2_r;
        mb = MB'(x_r);
      end
      MUL_A2Y: begin
        ma = a2_r;
        mb = MB'(y_r);
      end
      MUL_A2B: begin
        ma = a2_r;
        mb = MB'(semi_axis_y);
      end
      MUL_XX1: begin
        ma = MA'(x_r);
        mb = MB'(x_r) + MB'(1);
      end
      MUL_YSQ: begin
        ma = MA'(ym1_abs);
        mb = MB'(ym1_abs);
      end
      MUL_B2T1: begin
        ma = b2_r;
        mb = t1_r;
      end
      MUL_A2T2: begin
        ma = a2_r;
        mb = t2_r;
      end
      MUL_A2B2: begin
        ma = a2_r;
        mb = MB'(b2_r);
      end
      default: begin
        ma = '0;
        mb = '0;
      end
    endcase
  end

  assign prod = PW'(ma) * PW'(mb);

  always_ff @(posedge clk) begin
    unique case (cmd.mul_op)
      MUL_AA:   a2_r <= prod[MA-1:0];
      MUL_BB:   b2_r <= prod[MA-1:0];
      MUL_B2X:  bx_r <= prod;
      MUL_A2Y:  ay_r <= prod;
      MUL_XX1:  t1_r <= prod[MB-1:0];
      MUL_YSQ:  t2_r <= prod[MB-1:0];
      MUL_A2B, MUL_B2T1, MUL_A2T2, MUL_A2B2: m_r <= prod;
      default: ;
    endcase
  end

  assign a2x3 = {1'b0, a2_r, 1'b0} + {2'b00, a2_r};
  assign b2x3 = {1'b0, b2_r, 1'b0} + {2'b00, b2_r};

  always_comb begin
    unique case (cmd.acc_src)
      SRC_A2:   term = DEC_W'(a2_r);
      SRC_4B2:  term = DEC_W'(b2_r) << 2;
      SRC_4M:   term = DEC_W'(m_r) << 2;
      SRC_B2:   term = DEC_W'(b2_r);
      SRC_8BX:  term = DEC_W'(bx_r) << 3;
      SRC_8AY:  term = DEC_W'(ay_r) << 3;
      SRC_8A2:  term = DEC_W'(a2_r) << 3;
      SRC_8B2:  term = DEC_W'(b2_r) << 3;
      SRC_12A2: term = DEC_W'(a2x3) << 2;
      SRC_12B2: term = DEC_W'(b2x3) << 2;
      default:  term = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      d_r <= '0;
      x_r <= '0;
      y_r <= '0;
    end else begin
      unique case (cmd.acc_op)
        ACC_HOLD: d_r <= d_r;
        ACC_LOAD: d_r <= term;
        ACC_ADD:  d_r <= d_r + term;
        ACC_SUB:  d_r <= d_r - term;
      endcase
      if (cmd.off_load) begin
        x_r <= '0;
        y_r <= OFF_BITS'(semi_axis_y);
      end else begin
        if (cmd.x_inc) begin
          x_r <= x_r + OFF_BITS'(1);
        end
        if (cmd.y_dec) begin
          y_r <= y_r - OFF_BITS'(1);
        end
      end
    end
  end

  assign sts.below    = bx_r < ay_r;
  assign sts.dec_neg  = d_r[DEC_W-1];
  assign sts.dec_zero = (d_r == '0);
  assign sts.y_zero   = (y_r == '0);

  logic signed [SW-1:0] cx_e, cy_e, ox_e, oy_e;
  logic signed [SW-1:0] xp_w, xm_w, yp_w, ym_w;

  assign cx_e = SW'(center_x);
  assign cy_e = SW'(center_y);
  assign ox_e = SW'(x_r);
  assign oy_e = SW'(y_r);
  assign xp_w = cx_e + ox_e;
  assign xm_w = cx_e - ox_e;
  assign yp_w = cy_e + oy_e;
  assign ym_w = cy_e - oy_e;

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      if (cmd.emit_fin) begin
        x_plus  <= '0;
        x_minus <= '0;
        y_plus  <= '0;
        y_minus <= '0;
      end else begin
        x_plus  <= xp_w[OUT_BITS-1:0];
        x_minus <= xm_w[OUT_BITS-1:0];
        y_plus  <= yp_w[OUT_BITS-1:0];
        y_minus <= ym_w[OUT_BITS-1:0];
      end
      last_step <= cmd.emit_last;
      finished  <= cmd.emit_fin;
    end
  end

endmodule

FILE: design/mes_ctrl.sv
`include "assert_macros.svh"

module mes_ctrl import mes_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_tvalid,
  output logic     in_tready,
  input  logic     restart,
  output logic     out_tvalid,
  input  logic     out_tready,
  output mes_cmd_t cmd,
  input  mes_sts_t sts
);

  localparam int ST_W = 5;
  localparam logic [ST_W-1:0] ST_IDLE = 5'd0;
  localparam logic [ST_W-1:0] ST_R0   = 5'd1;
  localparam logic [ST_W-1:0] ST_R1   = 5'd2;
  localparam logic [ST_W-1:0] ST_R2   = 5'd3;
  localparam logic [ST_W-1:0] ST_R3   = 5'd4;
  localparam logic [ST_W-1:0] ST_R4   = 5'd5;
  localparam logic [ST_W-1:0] ST_REM  = 5'd6;
  localparam logic [ST_W-1:0] ST_FIN  = 5'd7;
  localparam logic [ST_W-1:0] ST_S0   = 5'd8;
  localparam logic [ST_W-1:0] ST_S1   = 5'd9;
  localparam logic [ST_W-1:0] ST_S2   = 5'd10;
  localparam logic [ST_W-1:0] ST_S3   = 5'd11;
  localparam logic [ST_W-1:0] ST_S4   = 5'd12;
  localparam logic [ST_W-1:0] ST_W0   = 5'd13;
  localparam logic [ST_W-1:0] ST_W1   = 5'd14;
  localparam logic [ST_W-1:0] ST_W2   = 5'd15;
  localparam logic [ST_W-1:0] ST_W3   = 5'd16;
  localparam logic [ST_W-1:0] ST_W4   = 5'd17;
  localparam logic [ST_W-1:0] ST_W5   = 5'd18;
  localparam logic [ST_W-1:0] ST_U0   = 5'd19;
  localparam logic [ST_W-1:0] ST_U1   = 5'd20;
  localparam logic [ST_W-1:0] ST_U2   = 5'd21;
  localparam logic [ST_W-1:0] ST_U3   = 5'd22;
  localparam logic [ST_W-1:0] ST_U4   = 5'd23;

  // Update paths: region and decision sign.
  localparam logic [1:0] P1_NEG = 2'd0;
  localparam logic [1:0] P1_POS = 2'd1;
  localparam logic [1:0] P2_POS = 2'd2;
  localparam logic [1:0] P2_DIAG = 2'd3;

  logic [ST_W-1:0] state_r, state_nxt;
  logic [1:0]      path_r, path_nxt;
  logic            r2_r, r2_nxt;
  logic            act_r, act_nxt;
  logic            last_r, last_nxt;
  logic            out_valid_r, out_valid_nxt;
  logic            slot_free;
  logic            sw;

  assign slot_free  = !out_valid_r || out_tready;
  assign in_tready  = (state_r == ST_IDLE);
  assign out_tvalid = out_valid_r;
  assign sw         = !r2_r && !sts.below;

  always_comb begin
    state_nxt = state_r;
    path_nxt  = path_r;
    r2_nxt    = r2_r;
    act_nxt   = act_r;
    last_nxt  = last_r;
    cmd       = '0;
    unique case (state_r)
      ST_IDLE: begin
        if (in_tvalid) begin
          if (restart) begin
            state_nxt = ST_R0;
          end else if (!act_r) begin
            state_nxt = ST_FIN;
          end else begin
            state_nxt = ST_S0;
          end
        end
      end
      ST_R0: begin
        cmd.mul_op   = MUL_AA;
        cmd.off_load = 1'b1;
        r2_nxt       = 1'b0;
        act_nxt      = 1'b1;
        state_nxt    = ST_R1;
      end
      ST_R1: begin
        cmd.mul_op = MUL_BB;
        state_nxt  = ST_R2;
      end
      ST_R2: begin
        cmd.mul_op  = MUL_A2B;
        cmd.acc_op  = ACC_LOAD;
        cmd.acc_src = SRC_A2;
        state_nxt   = ST_R3;
      end
      ST_R3: begin
        cmd.acc_op  = ACC_ADD;
        cmd.acc_src = SRC_4B2;
        state_nxt   = ST_R4;
      end
      ST_R4: begin
        cmd.acc_op  = ACC_SUB;
        cmd.acc_src = SRC_4M;
        state_nxt   = ST_REM;
      end
      ST_REM: begin
        if (slot_free) begin
          cmd.emit  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      ST_FIN: begin
        if (slot_free) begin
          cmd.emit     = 1'b1;
          cmd.emit_fin = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      ST_S0: begin
        cmd.mul_op = MUL_AA;
        state_nxt  = ST_S1;
      end
      ST_S1: begin
        cmd.mul_op = MUL_BB;
        state_nxt  = ST_S2;
      end
      ST_S2: begin
        cmd.mul_op = MUL_B2X;
        state_nxt  = ST_S3;
      end
      ST_S3: begin
        cmd.mul_op = MUL_A2Y;
        state_nxt  = ST_S4;
      end
      ST_S4: begin
        if (slot_free) begin
          cmd.emit      = 1'b1;
          cmd.emit_last = (r2_r || sw) && sts.y_zero;
          last_nxt      = (r2_r || sw) && sts.y_zero;
          state_nxt     = sw ? ST_W0 : ST_U0;
        end
      end
      ST_W0: begin
        cmd.mul_op = MUL_XX1;
        state_nxt  = ST_W1;
      end
      ST_W1: begin
        cmd.mul_op = MUL_YSQ;
        state_nxt  = ST_W2;
      end
      ST_W2: begin
        cmd.mul_op  = MUL_B2T1;
        cmd.acc_op  = ACC_LOAD;
        cmd.acc_src = SRC_B2;
        state_nxt   = ST_W3;
      end
      ST_W3: begin
        cmd.mul_op  = MUL_A2T2;
        cmd.acc_op  = ACC_ADD;
        cmd.acc_src = SRC_4M;
        state_nxt   = ST_W4;
      end
      ST_W4: begin
        cmd.mul_op  = MUL_A2B2;
        cmd.acc_op  = ACC_ADD;
        cmd.acc_src = SRC_4M;
        state_nxt   = ST_W5;
      end
      ST_W5: begin
        cmd.acc_op  = ACC_SUB;
        cmd.acc_src = SRC_4M;
        r2_nxt      = 1'b1;
        state_nxt   = ST_U0;
      end
      ST_U0: begin
        if (!r2_r) begin
          path_nxt = sts.dec_neg ? P1_NEG : P1_POS;
        end else begin
          path_nxt = (!sts.dec_neg && !sts.dec_zero) ? P2_POS : P2_DIAG;
        end
        state_nxt = ST_U1;
      end
      ST_U1: begin
        cmd.acc_op  = ACC_ADD;
        cmd.acc_src = (path_r == P2_POS) ? SRC_12A2 : SRC_8BX;
        state_nxt   = ST_U2;
      end
      ST_U2: begin
        if (path_r == P1_NEG) begin
          cmd.acc_op  = ACC_ADD;
          cmd.acc_src = SRC_12B2;
          cmd.x_inc   = 1'b1;
          state_nxt   = ST_IDLE;
        end else begin
          cmd.acc_op  = ACC_SUB;
          cmd.acc_src = SRC_8AY;
          if (path_r == P2_POS) begin
            cmd.y_dec = 1'b1;
            if (last_r) begin
              act_nxt = 1'b0;
            end
            state_nxt = ST_IDLE;
          end else begin
            state_nxt = ST_U3;
          end
        end
      end
      ST_U3: begin
        cmd.acc_op  = ACC_ADD;
        cmd.acc_src = (path_r == P1_POS) ? SRC_8A2 : SRC_8B2;
        state_nxt   = ST_U4;
      end
      ST_U4: begin
        cmd.acc_op  = ACC_ADD;
        cmd.acc_src = (path_r == P1_POS) ? SRC_12B2 : SRC_12A2;
        cmd.x_inc   = 1'b1;
        cmd.y_dec   = 1'b1;
        if (path_r == P2_DIAG && last_r) begin
          act_nxt = 1'b0;
        end
        state_nxt = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    if (cmd.emit) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      path_r      <= P1_NEG;
      r2_r        <= 1'b0;
      act_r       <= 1'b0;
      last_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      path_r      <= path_nxt;
      r2_r        <= r2_nxt;
      act_r       <= act_nxt;
      last_r      <= last_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  `ASSERT_IMPLIES(a_emit_slot_free, clk, rst_n, cmd.emit, !out_valid_r || out_tready)
  `ASSERT_NEXT(a_accept_leaves_idle, clk, rst_n, in_tvalid && in_tready, state_r != ST_IDLE)
  `ASSERT_IMPLIES(a_active_drop_after_last, clk, rst_n, $fell(act_r), $past(last_r))
  `ASSERT_IMPLIES(a_region_clear_on_restart, clk, rst_n, $fell(r2_r), $past(state_r == ST_R0))

endmodule

FILE: design/midpoint_ellipse_stepper.sv
// A new beat is accepted only once the previous beat's update has finished, and a result
// waits in the output register until it is taken. The step that enters region 2 also computes
// the region-2 start value. The pace is set by the single shared multiplier and the one-term
// decision adder.
// Reset (rst_n low, synchronous): configuration clears to zero and no ellipse is active.
module midpoint_ellipse_stepper import mes_pkg::*; #(
  parameter int  AXIS_BITS   = AXIS_BITS_DEF,
  parameter int  COORD_BITS  = COORD_BITS_DEF,
  localparam int CFG_W       = (COORD_BITS > AXIS_BITS) ? COORD_BITS : AXIS_BITS,
  localparam int OUT_TDATA_W = ((4 * (COORD_BITS + 1) + 7) / 8) * 8
) (
  input  logic                   clk,
  input  logic                   rst_n,
  // Configuration write port.
  input  logic                   cfg_we,
  input  logic [CFG_IDX_W-1:0]   cfg_addr,
  input  logic [CFG_W-1:0]       cfg_wdata,
  // Input stream. tdata: restart (bit 0), zero padding above.
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [IN_TDATA_W-1:0]  in_tdata,
  // Result stream. tdata from bit 0 up: x_plus, x_minus, y_plus, y_minus, zero padding.
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata,
  output logic                   out_tlast,   // last_step
  output logic                   out_tuser    // finished
);

  localparam int OUT_BITS = COORD_BITS + 1;

  // Configuration registers. They are read live on every step, so a write between beats
  // takes effect on the next beat; the decision variable and y offset keep their restart setup.
  logic signed [COORD_BITS-1:0] center_x_r, center_y_r;
  logic [AXIS_BITS-1:0]         semi_axis_x_r, semi_axis_y_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      center_x_r    <= '0;
      center_y_r    <= '0;
      semi_axis_x_r <= '0;
      semi_axis_y_r <= '0;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        CFG_CENTER_X: center_x_r    <= cfg_wdata[COORD_BITS-1:0];
        CFG_CENTER_Y: center_y_r    <= cfg_wdata[COORD_BITS-1:0];
        CFG_AXIS_X:   semi_axis_x_r <= cfg_wdata[AXIS_BITS-1:0];
        CFG_AXIS_Y:   semi_axis_y_r <= cfg_wdata[AXIS_BITS-1:0];
      endcase
    end
  end

  mes_cmd_t cmd;
  mes_sts_t sts;

  logic [OUT_BITS-1:0] x_plus, x_minus, y_plus, y_minus;
  logic                last_step, finished;

  // The controller sequences each step beat: squares of the semi-axes, the region test
  // products, the region-2 start value when the test switches regions, then the decision update
  // one term per cycle. The output register is loaded as soon as it is free, so the result can
  // wait downstream while the rest of the update finishes.
  mes_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .restart    (in_tdata[0]),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .cmd        (cmd),
    .sts        (sts)
  );

  // The datapath holds the offsets, the four-times-scaled decision variable, one shared
  // multiplier with its product registers, and the output payload register.
  mes_datapath #(
    .AXIS_BITS  (AXIS_BITS),
    .COORD_BITS (COORD_BITS)
  ) u_datapath (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd         (cmd),
    .sts         (sts),
    .center_x    (center_x_r),
    .center_y    (center_y_r),
    .semi_axis_x (semi_axis_x_r),
    .semi_axis_y (semi_axis_y_r),
    .x_plus      (x_plus),
    .x_minus     (x_minus),
    .y_plus      (y_plus),
    .y_minus     (y_minus),
    .last_step   (last_step),
    .finished    (finished)
  );

  assign out_tdata = OUT_TDATA_W'({y_minus, y_plus, x_minus, x_plus});
  assign out_tlast = last_step;
  assign out_tuser = finished;

endmodule
